[hw/rtl/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/sswp_pkg.sv]
// Types, constants and alphabet lookups for the short string word packer.
package sswp_pkg;

  localparam int unsigned SMALL_BITS = 5;
  localparam int unsigned MID_BITS   = 6;
  localparam int unsigned FULL_BITS  = 7;
  localparam int unsigned CNT_W      = 4;
  localparam logic [CNT_W-1:0] COUNT_SAT = 4'd13;

  localparam logic [1:0] TAG_NONE  = 2'd0;
  localparam logic [1:0] TAG_FULL  = 2'd1;
  localparam logic [1:0] TAG_MID   = 2'd2;
  localparam logic [1:0] TAG_SMALL = 2'd3;

  localparam int unsigned FIT_FULL  = 0;
  localparam int unsigned FIT_MID   = 1;
  localparam int unsigned FIT_SMALL = 2;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       char_valid;
    logic       is_last;
  } sswp_item_t;

  typedef struct packed {
    logic       fits;
    logic [1:0] alphabet_used;
  } sswp_tag_t;

  typedef struct packed {
    logic                  hit;
    logic [SMALL_BITS-1:0] code;
  } sswp_code_s_t;

  typedef struct packed {
    logic                hit;
    logic [MID_BITS-1:0] code;
  } sswp_code_m_t;

  function automatic sswp_code_s_t code_small(input logic [7:0] b);
    sswp_code_s_t r;
    r.hit  = 1'b1;
    r.code = '0;
    if (b >= 8'h61 && b <= 8'h7a) begin
      r.code = 5'(b - 8'd92);
    end else begin
      case (b)
        8'h00: r.code = 5'd0;
        8'h2d: r.code = 5'd1;
        8'h21: r.code = 5'd2;
        8'h60: r.code = 5'd3;
        8'h26: r.code = 5'd4;
        default: r.hit = 1'b0;
      endcase
    end
    return r;
  endfunction

  function automatic sswp_code_m_t code_mid(input logic [7:0] b);
    sswp_code_m_t r;
    r.hit  = 1'b1;
    r.code = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r.code = 6'(b - 8'd35);
    end else if (b >= 8'h61 && b <= 8'h7a) begin
      r.code = 6'(b - 8'd74);
    end else if (b >= 8'h41 && b <= 8'h47) begin
      r.code = 6'(b - 8'd16);
    end else begin
      case (b)
        8'h00: r.code = 6'd0;
        8'h2d: r.code = 6'd1;
        8'h2b: r.code = 6'd2;
        8'h2f: r.code = 6'd3;
        8'h2a: r.code = 6'd4;
        8'h28: r.code = 6'd5;
        8'h29: r.code = 6'd6;
        8'h20: r.code = 6'd7;
        8'h21: r.code = 6'd8;
        8'h3d: r.code = 6'd9;
        8'h3c: r.code = 6'd10;
        8'h3e: r.code = 6'd11;
        8'h2e: r.code = 6'd12;
        8'h49: r.code = 6'd56;
        8'h4e: r.code = 6'd57;
        8'h4f: r.code = 6'd58;
        8'h50: r.code = 6'd59;
        8'h52: r.code = 6'd60;
        8'h53: r.code = 6'd61;
        8'h54: r.code = 6'd62;
        default: r.hit = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

[hw/rtl/sswp_if.sv]
// Valid/ready channel interfaces for the packer's input and result words.
interface sswp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       char_valid;
  logic       is_last;

  modport source (output valid, output char_byte, output char_valid, output is_last,
                  input ready);
  modport sink   (input valid, input char_byte, input char_valid, input is_last,
                  output ready);
endinterface

interface sswp_out_if #(parameter int WORD_BITS = 64);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] packed_word;
  logic                 fits;
  logic [1:0]           alphabet_used;

  modport source (output valid, output packed_word, output fits, output alphabet_used,
                  input ready);
  modport sink   (input valid, input packed_word, input fits, input alphabet_used,
                  output ready);
endinterface

[hw/rtl/sswp_core.sv]
// Packing state: per-alphabet accumulators, fit flags and character count.
module sswp_core import sswp_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  sswp_item_t           item,
  output logic [WORD_BITS-1:0] res_word,
  output sswp_tag_t            res_tag
);

  localparam int S_MAX = (WORD_BITS - 2) / SMALL_BITS;
  localparam int M_MAX = (WORD_BITS - 2) / MID_BITS;
  localparam int F_MAX = (WORD_BITS - 2) / FULL_BITS;
  localparam int S_W   = S_MAX * SMALL_BITS;
  localparam int M_W   = M_MAX * MID_BITS;
  localparam int F_W   = F_MAX * FULL_BITS;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [S_W-1:0]   acc_s_r, acc_s_nxt;
  logic [M_W-1:0]   acc_m_r, acc_m_nxt;
  logic [F_W-1:0]   acc_f_r, acc_f_nxt;
  logic [2:0]       fit_r, fit_nxt;

  sswp_code_s_t     cs;
  sswp_code_m_t     cm;
  logic             f_hit;
  logic [5:0]       cnt6;

  always_comb begin
    cs    = code_small(item.char_byte);
    cm    = code_mid(item.char_byte);
    f_hit = !item.char_byte[7] && (item.char_byte[6:0] != 7'h7f);
    cnt6  = 6'(count_r);

    count_nxt = count_r;
    acc_s_nxt = acc_s_r;
    acc_m_nxt = acc_m_r;
    acc_f_nxt = acc_f_r;
    fit_nxt   = fit_r;

    if (item.char_valid) begin
      if (cs.hit && (count_r < CNT_W'(S_MAX)))
        acc_s_nxt = acc_s_r | (S_W'(cs.code) << (cnt6 * 6'(SMALL_BITS)));
      else
        fit_nxt[FIT_SMALL] = 1'b0;
      if (cm.hit && (count_r < CNT_W'(M_MAX)))
        acc_m_nxt = acc_m_r | (M_W'(cm.code) << (cnt6 * 6'(MID_BITS)));
      else
        fit_nxt[FIT_MID] = 1'b0;
      if (f_hit && (count_r < CNT_W'(F_MAX)))
        acc_f_nxt = acc_f_r | (F_W'(item.char_byte[6:0]) << (cnt6 * 6'(FULL_BITS)));
      else
        fit_nxt[FIT_FULL] = 1'b0;
      if (count_r < COUNT_SAT)
        count_nxt = count_r + 1'b1;
    end

    if (fit_nxt[FIT_SMALL]) begin
      res_word = WORD_BITS'({acc_s_nxt, 2'b00}) | WORD_BITS'(TAG_SMALL);
      res_tag  = '{fits: 1'b1, alphabet_used: TAG_SMALL};
    end else if (fit_nxt[FIT_MID]) begin
      res_word = WORD_BITS'({acc_m_nxt, 2'b00}) | WORD_BITS'(TAG_MID);
      res_tag  = '{fits: 1'b1, alphabet_used: TAG_MID};
    end else if (fit_nxt[FIT_FULL]) begin
      res_word = WORD_BITS'({acc_f_nxt, 2'b00}) | WORD_BITS'(TAG_FULL);
      res_tag  = '{fits: 1'b1, alphabet_used: TAG_FULL};
    end else begin
      res_word = '0;
      res_tag  = '{fits: 1'b0, alphabet_used: TAG_NONE};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.is_last)) begin
      count_r <= '0;
      acc_s_r <= '0;
      acc_m_r <= '0;
      acc_f_r <= '0;
      fit_r   <= 3'b111;
    end else if (step) begin
      count_r <= count_nxt;
      acc_s_r <= acc_s_nxt;
      acc_m_r <= acc_m_nxt;
      acc_f_r <= acc_f_nxt;
      fit_r   <= fit_nxt;
    end
  end

endmodule

[hw/rtl/short_string_word_packer.sv]
// Top level of the short string word packer.
//
//   channel | dir | words                                   | handshake
//   in_ch   | in  | char_byte, char_valid, is_last          | valid/ready
//   out_ch  | out | packed_word, fits, alphabet_used        | valid/ready
//
// One input word per cycle while the output is not stalled; the result for a word
// marked is_last passes through the input register, then the result register.
// Non-last words drain from the input register every cycle; a last word waits
// on a full result register, so a stalled output stops input once a last word
// reaches the input register.
// Reset (synchronous) empties both registers and restores the packing state.
module short_string_word_packer import sswp_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  sswp_in_if.sink    in_ch,
  sswp_out_if.source out_ch
);

  logic                 s1_valid_r;
  sswp_item_t           s1_item_r;
  logic                 s1_go;
  logic                 out_free;
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] out_word_r;
  sswp_tag_t            out_tag_r;
  logic [WORD_BITS-1:0] res_word;
  sswp_tag_t            res_tag;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_go       = s1_valid_r && (!s1_item_r.is_last || out_free);
  assign in_ch.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_item_r <= '{char_byte: in_ch.char_byte, char_valid: in_ch.char_valid,
                     is_last: in_ch.is_last};
    end
  end

  sswp_core #(.WORD_BITS(WORD_BITS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (s1_go),
    .item     (s1_item_r),
    .res_word (res_word),
    .res_tag  (res_tag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_item_r.is_last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_item_r.is_last) begin
      out_word_r <= res_word;
      out_tag_r  <= res_tag;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.packed_word   = out_word_r;
  assign out_ch.fits          = out_tag_r.fits;
  assign out_ch.alphabet_used = out_tag_r.alphabet_used;

endmodule

[hw/rtl/sswp_checker.sv]
// Port-level assertions for the short string word packer, bound to the top.
`include "assert_macros.svh"

module sswp_checker import sswp_pkg::*; #(
  parameter int WORD_BITS = 64
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [WORD_BITS-1:0] out_packed_word,
  input logic                 out_fits,
  input logic [1:0]           out_alphabet_used
);

  `ASSERT_CLK_NR(a_reset_empty, clk, !rst_n |=> !out_valid, "result word valid after reset")

  `ASSERT_CLK(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_packed_word), "stalled result word dropped or changed")

  `ASSERT_CLK(a_fit_tag, clk, rst_n, out_valid |-> (out_fits == (out_alphabet_used != TAG_NONE)), "fits disagrees with alphabet")

  `ASSERT_CLK(a_word_tag, clk, rst_n, out_valid |-> (out_packed_word[1:0] == out_alphabet_used) && (out_fits || (out_packed_word == '0)), "word tag bits wrong")

endmodule

bind short_string_word_packer sswp_checker #(.WORD_BITS(WORD_BITS)) u_sswp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_packed_word   (out_ch.packed_word),
  .out_fits          (out_ch.fits),
  .out_alphabet_used (out_ch.alphabet_used)
);

[tb/testbench.sv]
// Self-checking testbench for the short string word packer: directed and random
// strings with a predictor and in-order result checking.
module testbench;
  import sswp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_BITS  = 64;
  localparam int SMALL_MAX  = (WORD_BITS - 2) / SMALL_BITS;
  localparam int MID_MAX    = (WORD_BITS - 2) / MID_BITS;
  localparam int FULL_MAX   = (WORD_BITS - 2) / FULL_BITS;
  localparam int RAND_ITEMS = 1900;
  localparam int QUIET_TAIL = 150;
  localparam int LONG_HOLD  = 300;
  localparam int STALL_MAX  = 3000;

  localparam string SMALL_CHARS = "-!`&abcdefghijklmnopqrstuvwxyz";
  localparam string MID_CHARS =
    "-+/*() !=<>.0123456789abcdefghijklmnopqrstuvwxyzABCDEFGINOPRST";

  typedef struct {
    sswp_item_t word;
    bit         drain_first;
  } send_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] packed_word;
    logic                 fits;
    logic [1:0]           alphabet_used;
  } packed_result_t;

  logic clk;
  logic rst_n;

  sswp_in_if                           in_ch();
  sswp_out_if #(.WORD_BITS(WORD_BITS)) out_ch();

  short_string_word_packer #(.WORD_BITS(WORD_BITS)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  send_t          chars_to_send[$];
  packed_result_t results_due[$];

  int small_code[256];
  int mid_code[256];

  logic [CNT_W-1:0] n_chars;
  logic [59:0]      acc_small;
  logic [59:0]      acc_mid;
  logic [55:0]      acc_full;
  logic [2:0]       fit_flags;

  int   fails;
  int   results_seen;
  int   idle_cycles;
  int   src_gap;
  int   sink_gap;
  int   hold_left;
  bit   held_once;
  logic in_taken;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void build_alphabets();
    for (int i = 0; i < 256; i++) begin
      small_code[i] = -1;
      mid_code[i]   = -1;
    end
    small_code[0] = 0;
    mid_code[0]   = 0;
    for (int i = 0; i < SMALL_CHARS.len(); i++) small_code[SMALL_CHARS[i]] = i + 1;
    for (int i = 0; i < MID_CHARS.len(); i++) mid_code[MID_CHARS[i]] = i + 1;
  endfunction

  function automatic void clear_pack_state();
    n_chars   = '0;
    acc_small = '0;
    acc_mid   = '0;
    acc_full  = '0;
    fit_flags = 3'b111;
  endfunction

  function automatic void pack_step(sswp_item_t w);
    packed_result_t r;
    int cs;
    int cm;
    if (w.char_valid) begin
      cs = small_code[w.char_byte];
      cm = mid_code[w.char_byte];
      if (cs < 0 || n_chars >= SMALL_MAX) fit_flags[FIT_SMALL] = 1'b0;
      else acc_small = acc_small | (60'(cs) << (SMALL_BITS * n_chars));
      if (cm < 0 || n_chars >= MID_MAX) fit_flags[FIT_MID] = 1'b0;
      else acc_mid = acc_mid | (60'(cm) << (MID_BITS * n_chars));
      if (w.char_byte >= 8'd127 || n_chars >= FULL_MAX) fit_flags[FIT_FULL] = 1'b0;
      else acc_full = acc_full | (56'(w.char_byte) << (FULL_BITS * n_chars));
      if (n_chars < COUNT_SAT) n_chars = n_chars + 1'b1;
    end
    if (w.is_last) begin
      if (fit_flags[FIT_SMALL])
        r = '{(WORD_BITS'(acc_small) << 2) | WORD_BITS'(TAG_SMALL), 1'b1, TAG_SMALL};
      else if (fit_flags[FIT_MID])
        r = '{(WORD_BITS'(acc_mid) << 2) | WORD_BITS'(TAG_MID), 1'b1, TAG_MID};
      else if (fit_flags[FIT_FULL])
        r = '{(WORD_BITS'(acc_full) << 2) | WORD_BITS'(TAG_FULL), 1'b1, TAG_FULL};
      else
        r = '{'0, 1'b0, TAG_NONE};
      results_due.push_back(r);
      clear_pack_state();
    end
  endfunction

  function automatic void add_word(logic [7:0] b, logic v, logic l);
    send_t s;
    s.word        = '{b, v, l};
    s.drain_first = 1'b0;
    chars_to_send.push_back(s);
  endfunction

  function automatic void add_drain();
    send_t s;
    s.word        = '0;
    s.drain_first = 1'b1;
    chars_to_send.push_back(s);
  endfunction

  function automatic logic [7:0] pick_char(int kind);
    int idx;
    if ($urandom_range(0, 19) == 0) return 8'($urandom_range(0, 255));
    case (kind)
      0, 1, 2, 3: begin
        idx = $urandom_range(0, SMALL_CHARS.len());
        return (idx == 0) ? 8'h00 : SMALL_CHARS[idx-1];
      end
      4, 5: begin
        idx = $urandom_range(0, MID_CHARS.len());
        return (idx == 0) ? 8'h00 : MID_CHARS[idx-1];
      end
      6, 7: return 8'($urandom_range(0, 126));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void make_strings(int target);
    int counted;
    int next_drain;
    int kind;
    int len;
    bit split_end;
    counted    = 0;
    next_drain = 700;
    while (counted < target) begin
      if (counted >= next_drain) begin
        add_drain();
        next_drain += 700;
      end
      kind = $urandom_range(0, 9);
      if (kind == 9) len = 0;
      else if ($urandom_range(0, 3) == 0) len = $urandom_range(9, 15);
      else len = $urandom_range(1, 8);
      split_end = ($urandom_range(0, 4) == 0);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 14) == 0) add_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        add_word(pick_char(kind), 1'b1, (k == len - 1) && !split_end);
        counted++;
      end
      if (len == 0 || split_end) begin
        add_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
        counted++;
      end
    end
  endfunction

  // source side
  always @(negedge clk) begin : drive_chars
    send_t nxt;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (chars_to_send.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (chars_to_send[0].drain_first) begin
        in_ch.valid <= 1'b0;
        if (results_due.size() == 0) void'(chars_to_send.pop_front());
      end else if (chars_to_send.size() > QUIET_TAIL && $urandom_range(0, 9) == 0) begin
        src_gap <= $urandom_range(0, 7);
        in_ch.valid <= 1'b0;
      end else begin
        nxt = chars_to_send.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.char_byte  <= nxt.word.char_byte;
        in_ch.char_valid <= nxt.word.char_valid;
        in_ch.is_last    <= nxt.word.is_last;
      end
    end
  end

  // sink side
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!held_once && results_seen >= 100) begin
      held_once <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (chars_to_send.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
      sink_gap <= $urandom_range(0, 7);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_words
    packed_result_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
      clear_pack_state();
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (results_due.size() == 0) begin
          $error("result word with nothing expected: packed_word %h", out_ch.packed_word);
          fails++;
        end else begin
          want = results_due.pop_front();
          if (out_ch.packed_word !== want.packed_word) begin
            $error("packed_word: expected %h, got %h", want.packed_word, out_ch.packed_word);
            fails++;
          end
          if (out_ch.fits !== want.fits) begin
            $error("fits: expected %0d, got %0d", want.fits, out_ch.fits);
            fails++;
          end
          if (out_ch.alphabet_used !== want.alphabet_used) begin
            $error("alphabet_used: expected %0d, got %0d", want.alphabet_used,
                   out_ch.alphabet_used);
            fails++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        pack_step('{in_ch.char_byte, in_ch.char_valid, in_ch.is_last});
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.char_byte  = '0;
    in_ch.char_valid = 1'b0;
    in_ch.is_last    = 1'b0;
    out_ch.ready     = 1'b0;
    fails            = 0;
    results_seen     = 0;
    idle_cycles      = 0;
    src_gap          = 0;
    sink_gap         = 0;
    hold_left        = 0;
    held_once        = 1'b0;
    in_taken         = 1'b0;
    build_alphabets();
    clear_pack_state();

    // empty string
    add_word(8'h00, 1'b0, 1'b1);
    // zero byte inside a small-set string
    add_word(8'h00, 1'b1, 1'b0);
    add_word("&", 1'b1, 1'b0);
    add_word("z", 1'b1, 1'b1);
    // mid-set char, skipped word, then bare end marker
    add_word("T", 1'b1, 1'b0);
    add_word(8'h5a, 1'b0, 1'b0);
    add_word(8'h00, 1'b0, 1'b1);
    // nothing fits / full set edge
    add_word(8'hff, 1'b1, 1'b1);
    add_word(8'h7e, 1'b1, 1'b1);
    add_word(8'h7f, 1'b1, 1'b1);
    // longest small-set string
    for (int i = 0; i < SMALL_MAX; i++) add_word(8'h61 + 8'(2 * i), 1'b1, i == SMALL_MAX - 1);

    make_strings(RAND_ITEMS);

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    while (chars_to_send.size() != 0 || in_ch.valid || results_due.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
    if (fails == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
